/* rtl/header_checksum_frame_sync_core_defines.svh */
// assertion helpers for the frame sync core, clocked on clk and held off by rst_n
`ifndef HEADER_CHECKSUM_FRAME_SYNC_CORE_DEFINES_SVH
`define HEADER_CHECKSUM_FRAME_SYNC_CORE_DEFINES_SVH

// same-cycle implication
`define HCFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hcfs_pkg.sv */
package hcfs_pkg;

    localparam int unsigned HELD_DEPTH = 7;
    localparam int unsigned FILL_W     = $clog2(HELD_DEPTH + 1);
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [7:0] HDR_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] HDR_SECOND_RESET = 8'hBB;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HELD_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FIRST  = 8'd0,
        REG_HEADER_SECOND = 8'd1
    } cfg_reg_t;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [15:0] check_word;
    } match_t;

endpackage

/* rtl/header_checksum_frame_sync_core.sv */
// byte-serial frame finder with a two-byte header and an additive check word
//
// s_tdata carries one received byte per item. the block keeps the last seven
// bytes; with the current byte they form an eight-byte window. when the window
// starts with the configured header pair and its last word equals the 16-bit
// sum of the two data words, one result item leaves on m_tdata and all eight
// bytes are dropped, otherwise the window slides by one byte.
// cfg_valid/cfg_index/cfg_data write header_first (index 0) and header_second
// (index 1); other indexes are ignored. cfg_ready is always high.
// a result appears on m_tvalid in the cycle after the byte that completes the
// frame. throughput: one byte per cycle while s_tready is high, set by the single
// window register update.
// reset clears the byte count and output valid and loads the headers with
// 0xaa and 0xbb. a stalled receiver holds the result in the output register;
// bytes keep flowing unless the window is full and could complete another
// frame, in which case s_tready drops until the result is taken.
`include "header_checksum_frame_sync_core_defines.svh"

module header_checksum_frame_sync_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,     // rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,     // first_word, second_word, check_word
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);
    import hcfs_pkg::*;

    byte_t             window_reg [HELD_DEPTH];
    byte_t             window_next [HELD_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    byte_t             hdr_first_reg;
    byte_t             hdr_second_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    match_t            match;
    logic              in_accept;
    logic              window_full;
    logic              frame_hit;

    hcfs_match u_match (
        .window        (window_reg),
        .cur_byte      (s_tdata),
        .header_first  (hdr_first_reg),
        .header_second (hdr_second_reg),
        .result        (match)
    );

    assign window_full = (fill_reg == FILL_FULL);
    // after a frame the next seven bytes cannot make a result, so they pass a stalled output
    assign s_tready    = !out_valid_reg || m_tready || !window_full;
    assign in_accept   = s_tvalid && s_tready;
    assign frame_hit   = in_accept && window_full && match.hit;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HDR_FIRST_RESET;
            hdr_second_reg <= HDR_SECOND_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                REG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (in_accept)
        begin
            if (!window_full)
            begin
                for (int k = 0; k < HELD_DEPTH; k++)
                begin
                    if (fill_reg == FILL_W'(k))
                        window_next[k] = s_tdata;
                end
                fill_next = fill_reg + 1'b1;
            end
            else if (match.hit)
            begin
                fill_next = '0;
            end
            else
            begin
                for (int k = 0; k < HELD_DEPTH - 1; k++)
                    window_next[k] = window_reg[k + 1];
                window_next[HELD_DEPTH - 1] = s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // window bytes are always written before they are read
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (frame_hit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_hit)
            out_data_reg <= {match.check_word, match.second_word, match.first_word};
    end

    `HCFS_ASSERT_NXT(a_hit_loads_output, frame_hit, out_valid_reg && (fill_reg == '0),
        "frame did not load the output or reset the byte count")
    `HCFS_ASSERT_IMP(a_stall_only_when_full, !s_tready,
        out_valid_reg && !m_tready && window_full,
        "input stalled without a pending result and a full window")
    `HCFS_ASSERT_NXT(a_fill_counts_up, in_accept && !window_full,
        fill_reg == $past(fill_reg) + 1'b1,
        "byte count did not advance while filling")
    `HCFS_ASSERT_IMP(a_no_overwrite, frame_hit, !out_valid_reg || m_tready,
        "result overwritten before it was taken")

endmodule

/* rtl/hcfs_match.sv */
module hcfs_match (
    input  hcfs_pkg::byte_t  window [hcfs_pkg::HELD_DEPTH],
    input  hcfs_pkg::byte_t  cur_byte,
    input  hcfs_pkg::byte_t  header_first,
    input  hcfs_pkg::byte_t  header_second,
    output hcfs_pkg::match_t result
);
    import hcfs_pkg::*;

    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] chk;
    logic [15:0] sum;

    assign w0  = {window[2], window[3]};
    assign w1  = {window[4], window[5]};
    assign chk = {window[6], cur_byte};
    // sum wraps at 16 bits
    assign sum = w0 + w1;

    always_comb
    begin
        result.hit         = (window[0] == header_first) && (window[1] == header_second)
                             && (chk == sum);
        result.first_word  = w0;
        result.second_word = w1;
        result.check_word  = chk;
    end

endmodule

/* verif/tb_header_checksum_frame_sync_core.sv */
`timescale 1ns / 100ps

module tb_header_checksum_frame_sync_core;
    import hcfs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned SETTLE      = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;     // rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [47:0]          m_tdata;     // first_word, second_word, check_word
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    bit          quiet;
    bit          hold_req;
    int unsigned cycles;
    int unsigned settings;

    // predicts frames from the accepted bytes and checks what leaves the block
    class frame_book;
        byte_t       hdr_first;
        byte_t       hdr_second;
        byte_t       held[HELD_DEPTH];
        int unsigned fill;
        logic [47:0] frame_q[$];
        int unsigned errors;
        int unsigned bytes_seen;
        int unsigned frames_seen;

        function new();
            hdr_first  = HDR_FIRST_RESET;
            hdr_second = HDR_SECOND_RESET;
            foreach (held[k])
                held[k] = '0;
            fill = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, byte_t val);
            if (idx == REG_HEADER_FIRST)
                hdr_first = val;
            else if (idx == REG_HEADER_SECOND)
                hdr_second = val;
        endfunction

        function void note_byte(byte_t cur);
            logic [15:0] w0;
            logic [15:0] w1;
            logic [15:0] chk;
            logic [15:0] sum;
            bytes_seen++;
            if (fill < HELD_DEPTH)
            begin
                held[fill] = cur;
                fill++;
                return;
            end
            w0  = {held[2], held[3]};
            w1  = {held[4], held[5]};
            chk = {held[6], cur};
            sum = w0 + w1;
            if (held[0] == hdr_first && held[1] == hdr_second && chk == sum)
            begin
                frame_q.push_back({chk, w1, w0});
                foreach (held[k])
                    held[k] = '0;
                fill = 0;
            end
            else
            begin
                for (int k = 0; k < HELD_DEPTH - 1; k++)
                    held[k] = held[k + 1];
                held[HELD_DEPTH - 1] = cur;
            end
        endfunction

        function void check_result(logic [47:0] got);
            string       field_name[3];
            logic [47:0] want;
            field_name = '{"first_word", "second_word", "check_word"};
            frames_seen++;
            if (frame_q.size() == 0)
            begin
                $display("%0t: unexpected frame item, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = frame_q.pop_front();
            for (int k = 0; k < 3; k++)
                if (got[16*k +: 16] !== want[16*k +: 16])
                begin
                    $display("%0t: %s expected %h actual %h", $time, field_name[k],
                             want[16*k +: 16], got[16*k +: 16]);
                    errors++;
                end
        endfunction
    endclass

    frame_book book = new();

    header_checksum_frame_sync_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("header_checksum_frame_sync_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            book.check_result(m_tdata);

    // receiver: short random stalls, one long hold on request
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input byte_t b);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input byte_t h0, input byte_t h1,
                              input logic [15:0] w0, input logic [15:0] w1,
                              input bit corrupt);
        logic [15:0] chk;
        byte_t       frame_bytes[8];
        chk = w0 + w1;
        frame_bytes = '{h0, h1, w0[15:8], w0[7:0], w1[15:8], w1[7:0], chk[15:8], chk[7:0]};
        // flip one bit anywhere, header included
        if (corrupt)
            frame_bytes[$urandom_range(0, 7)] ^= byte_t'(1 << $urandom_range(0, 7));
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k]);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // lower valid and wait until every frame has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.frame_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic configure(input byte_t first, input byte_t second);
        logic [CFG_IDX_W-1:0] stray;
        stray = CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1));
        write_reg(REG_HEADER_FIRST, first);
        write_reg(stray, byte_t'($urandom));
        write_reg(REG_HEADER_SECOND, second);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        stop_at = book.bytes_seen + count;
        while (book.bytes_seen < stop_at)
        begin
            case ($urandom_range(0, 9)) inside
                [0:5]:
                    send_frame(book.hdr_first, book.hdr_second, pick_word(), pick_word(), 1'b0);
                6:
                    send_frame(book.hdr_first, book.hdr_second, pick_word(), pick_word(), 1'b1);
                [7:8]:
                    repeat ($urandom_range(1, 5)) send_byte(byte_t'($urandom));
                default:
                begin
                    // stray header bytes ahead of a real frame
                    send_byte(book.hdr_first);
                    if ($urandom_range(0, 1))
                        send_byte(book.hdr_second);
                    send_frame(book.hdr_first, book.hdr_second, pick_word(), pick_word(), 1'b0);
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        byte_t directed[25];
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        cycles    = 0;
        settings  = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // frame with wrapping sum, a junk byte then a frame, then a bad check word
        directed = '{8'hAA, 8'hBB, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00,
                     8'h55,
                     8'hAA, 8'hBB, 8'h12, 8'h34, 8'h56, 8'h78, 8'h68, 8'hAC,
                     8'hAA, 8'hBB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        foreach (directed[k])
            send_byte(directed[k]);
        drain();

        random_traffic(340);
        drain();

        configure(8'h00, 8'h00);
        random_traffic(300);
        drain();

        // long receiver hold while frames keep arriving
        hold_req = 1'b1;
        repeat (5) send_frame(book.hdr_first, book.hdr_second, pick_word(), pick_word(), 1'b0);
        drain();

        configure(8'hFF, 8'hFF);
        random_traffic(300);
        drain();

        configure(byte_t'($urandom), byte_t'($urandom));
        random_traffic(300);
        drain();

        quiet = 1'b1;
        configure(byte_t'($urandom), byte_t'($urandom));
        random_traffic(380);
        drain();
        repeat (10) @(negedge clk);

        $display("run covered %0d bytes and %0d frames under %0d header settings",
                 book.bytes_seen, book.frames_seen, settings);
        $display("including corrupted frames, stray headers and a long output stall");
        if (book.errors == 0 && book.frame_q.size() == 0)
            $display("header_checksum_frame_sync_core: match");
        else
            $display("header_checksum_frame_sync_core: mismatch");
        $finish;
    end

endmodule
